/* sv/bsrr_pkg.sv */
`timescale 1ns / 1ps

package bsrr_pkg;

   localparam int BufDepthDefault = 256;
   localparam int BufDepth = 256;

   typedef enum logic [1:0] {
      FUNC_WRITE   = 2'd0,
      FUNC_READ    = 2'd1,
      FUNC_REVERSE = 2'd2,
      FUNC_ROTATE  = 2'd3
   } func_type;

   // classified command handed from front to back
   typedef struct packed {
      func_type    func;
      logic [7:0]  byte_index;
      logic [7:0]  write_value;
      logic [8:0]  start;
      logic [8:0]  len;
      logic [15:0] amount;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD,
      ST_PLAN,
      ST_RD_A,
      ST_RD_B,
      ST_WR_A,
      ST_WR_B,
      ST_NEXT,
      ST_READ_WAIT,
      ST_RESULT
   } back_state_type;

endpackage

/* sv/bsrr_front.sv */
`timescale 1ns / 1ps

module bsrr_front #(
   parameter int BUF_DEPTH = bsrr_pkg::BufDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [8:0]        used_size,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        func,
   input  logic [7:0]        byte_index,
   input  logic [7:0]        write_value,
   input  logic [15:0]       seg_start,
   input  logic [15:0]       seg_len,
   input  logic [15:0]       rotate_amount,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output bsrr_pkg::cmd_type cmd_data
);

   logic signed [17:0] size_s, start_s, end_s, len_s, st_a, en_a;
   logic              q_valid_ff, q_valid_in;
   bsrr_pkg::cmd_type q_ff, q_in, cls;

   // clamp start and length against the used size
   always_comb begin
      size_s = 18'(used_size);
      if (used_size == 9'd0) size_s = 18'sd1;
      else if (32'(used_size) > BUF_DEPTH) size_s = 18'(BUF_DEPTH);
      st_a = 18'(signed'(seg_start));
      en_a = 18'(signed'(seg_len));
      if (st_a < 0) begin
         start_s = size_s + st_a;
         if (start_s < 0) start_s = 18'sd0;
      end else if (st_a >= size_s) begin
         start_s = size_s - 18'sd1;
      end else begin
         start_s = st_a;
      end
      if (en_a <= 0) begin
         end_s = size_s + en_a;
         if (end_s < 0) end_s = 18'sd0;
      end else begin
         end_s = start_s + en_a;
         if (end_s > size_s) end_s = size_s;
      end
      len_s = end_s - start_s;
      if (len_s < 1) len_s = 18'sd0;
      cls.func        = bsrr_pkg::func_type'(func);
      cls.byte_index  = byte_index;
      cls.write_value = write_value;
      cls.start       = start_s[8:0];
      cls.len         = len_s[8:0];
      cls.amount      = rotate_amount;
   end

   // one-entry queue toward the back end
   assign in_ready = !q_valid_ff || cmd_ready;
   always_comb begin
      q_valid_in = q_valid_ff;
      q_in       = q_ff;
      if (cmd_ready) q_valid_in = 1'b0;
      if (in_valid && in_ready) begin
         q_valid_in = 1'b1;
         q_in       = cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) q_valid_ff <= 1'b0;
      else       q_valid_ff <= q_valid_in;
      q_ff <= q_in;
   end

   assign cmd_valid = q_valid_ff;
   assign cmd_data  = q_ff;

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      q_valid_ff |-> (10'(q_ff.start) + 10'(q_ff.len) <= 10'd256))
      else $error("clamped range exceeds buffer");

endmodule

/* sv/bsrr_back.sv */
`timescale 1ns / 1ps

module bsrr_back #(
   parameter int BUF_DEPTH = bsrr_pkg::BufDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  bsrr_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_read_value,
   output logic [7:0]        rsp_start,
   output logic [8:0]        rsp_len
);

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

   logic [7:0] mem [BUF_DEPTH];
   logic [7:0] rd_data_ff;
   logic       mem_we;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [7:0] mem_wd;

   bsrr_pkg::back_state_type state_ff, state_in;
   bsrr_pkg::cmd_type cmd_ff, cmd_in;
   logic [16:0] rem_ff, rem_in;      // magnitude remainder
   logic [4:0]  mbit_ff, mbit_in;
   logic [8:0]  sh_ff, sh_in;
   logic [1:0]  pass_ff, pass_in;
   logic [8:0]  lo_ff, lo_in, hi_ff, hi_in, cnt_ff, cnt_in;
   logic [7:0]  a_ff, a_in;
   logic [7:0]  rv_ff, rv_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  o_rv_ff, o_rv_in, o_st_ff, o_st_in;
   logic [8:0]  o_ln_ff, o_ln_in;
   logic [25:0] dsub;
   logic        idx_ok;

   assign idx_ok = 32'(cmd_ff.byte_index) < BUF_DEPTH;

   // byte store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_data_ff <= mem[mem_ra];
   end

   // length shifted to the current quotient bit, kept at full width
   assign dsub = 26'(cmd_ff.len) << (5'd16 - mbit_ff);

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; rem_in = rem_ff; mbit_in = mbit_ff;
      sh_in = sh_ff; pass_in = pass_ff; lo_in = lo_ff; hi_in = hi_ff;
      cnt_in = cnt_ff; a_in = a_ff; rv_in = rv_ff;
      rsp_valid_in = rsp_valid_ff; o_rv_in = o_rv_ff; o_st_in = o_st_ff;
      o_ln_in = o_ln_ff;
      mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_ra = '0;
      cmd_ready = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         bsrr_pkg::ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in = cmd_data;
               rv_in  = 8'd0;
               case (cmd_data.func)
                  bsrr_pkg::FUNC_WRITE: begin
                     mem_we   = 32'(cmd_data.byte_index) < BUF_DEPTH;
                     mem_wa   = AW'(cmd_data.byte_index);
                     mem_wd   = cmd_data.write_value;
                     state_in = bsrr_pkg::ST_RESULT;
                  end
                  bsrr_pkg::FUNC_READ: begin
                     mem_ra   = AW'(cmd_data.byte_index);
                     state_in = bsrr_pkg::ST_READ_WAIT;
                  end
                  bsrr_pkg::FUNC_REVERSE: begin
                     sh_in = 9'd0; pass_in = 2'd2;
                     state_in = bsrr_pkg::ST_PLAN;
                  end
                  default: begin
                     // modulo magnitude by restoring division, MSB first
                     rem_in  = {1'b0, cmd_data.amount[15] ? -cmd_data.amount
                                                          : cmd_data.amount};
                     mbit_in = 5'd0;
                     sh_in   = 9'd0;
                     pass_in = 2'd0;
                     state_in = (cmd_data.len == 9'd0) ? bsrr_pkg::ST_RESULT
                                                        : bsrr_pkg::ST_MOD;
                  end
               endcase
            end
         end
         bsrr_pkg::ST_MOD: begin
            // subtract len shifted; reduce by len<<k for k=16..0
            mbit_in = mbit_ff + 5'd1;
            if ({9'd0, rem_ff} >= dsub)
               rem_in = rem_ff - dsub[16:0];
            if (mbit_ff == 5'd16) begin
               state_in = bsrr_pkg::ST_PLAN;
            end
         end
         bsrr_pkg::ST_PLAN: begin
            // on first rotate entry set the shift, else pick the span for the current pass
            if (pass_ff == 2'd0 && cmd_ff.func == bsrr_pkg::FUNC_ROTATE
                && sh_ff == 9'd0 && mbit_ff == 5'd17) begin
               sh_in = (cmd_ff.amount[15] && rem_ff != 17'd0)
                       ? cmd_ff.len - rem_ff[8:0] : rem_ff[8:0];
               mbit_in = 5'd0;
            end else begin
               case (pass_ff)
                  2'd0: begin lo_in = cmd_ff.start; cnt_in = sh_ff; end
                  2'd1: begin
                     lo_in = cmd_ff.start + sh_ff; cnt_in = cmd_ff.len - sh_ff;
                  end
                  default: begin lo_in = cmd_ff.start; cnt_in = cmd_ff.len; end
               endcase
               hi_in = ((pass_ff == 2'd0) ? cmd_ff.start + sh_ff
                       : (pass_ff == 2'd1) ? cmd_ff.start + cmd_ff.len
                       : cmd_ff.start + cmd_ff.len) - 9'd1;
               state_in = bsrr_pkg::ST_NEXT;
            end
         end
         bsrr_pkg::ST_NEXT: begin
            if (lo_ff < hi_ff && cnt_ff > 9'd1) begin
               mem_ra   = AW'(lo_ff);
               state_in = bsrr_pkg::ST_RD_A;
            end else if (pass_ff == 2'd2) begin
               state_in = bsrr_pkg::ST_RESULT;
            end else begin
               pass_in  = pass_ff + 2'd1;
               state_in = bsrr_pkg::ST_PLAN;
            end
         end
         bsrr_pkg::ST_RD_A: begin
            // save the low byte, fetch the high byte
            a_in     = rd_data_ff;
            mem_ra   = AW'(hi_ff);
            state_in = bsrr_pkg::ST_RD_B;
         end
         bsrr_pkg::ST_RD_B: begin
            // hold the high byte on the read port
            mem_ra   = AW'(hi_ff);
            state_in = bsrr_pkg::ST_WR_A;
         end
         bsrr_pkg::ST_WR_A: begin
            // swap: high byte into low slot, saved low byte into high slot
            mem_we = 1'b1; mem_wa = AW'(lo_ff); mem_wd = rd_data_ff;
            state_in = bsrr_pkg::ST_WR_B;
         end
         bsrr_pkg::ST_WR_B: begin
            mem_we = 1'b1; mem_wa = AW'(hi_ff); mem_wd = a_ff;
            lo_in = lo_ff + 9'd1; hi_in = hi_ff - 9'd1;
            state_in = bsrr_pkg::ST_NEXT;
         end
         bsrr_pkg::ST_READ_WAIT: begin
            // capture the read byte
            rv_in    = rd_data_ff;
            state_in = bsrr_pkg::ST_RESULT;
         end
         bsrr_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               o_rv_in = (cmd_ff.func == bsrr_pkg::FUNC_READ && idx_ok)
                         ? rv_ff : 8'd0;
               o_st_in = cmd_ff.start[7:0];
               o_ln_in = cmd_ff.len;
               state_in = bsrr_pkg::ST_IDLE;
            end
         end
         default: state_in = bsrr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsrr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in; rem_ff <= rem_in; mbit_ff <= mbit_in; sh_ff <= sh_in;
      pass_ff <= pass_in; lo_ff <= lo_in; hi_ff <= hi_in; cnt_ff <= cnt_in;
      a_ff <= a_in; rv_ff <= rv_in; o_rv_ff <= o_rv_in; o_st_ff <= o_st_in;
      o_ln_ff <= o_ln_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = o_rv_ff;
   assign rsp_start      = o_st_ff;
   assign rsp_len        = o_ln_ff;

   a_rem_lt_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsrr_pkg::ST_PLAN && mbit_ff == 5'd17) |->
      (rem_ff < 17'(cmd_ff.len)))
      else $error("modulo remainder not reduced");
   a_swap_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsrr_pkg::ST_WR_B) |-> (lo_ff < hi_ff))
      else $error("swap pointers crossed");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_ready |-> (state_ff == bsrr_pkg::ST_IDLE))
      else $error("command taken while busy");

endmodule

/* sv/byte_segment_reverse_rotate_core.sv */
`timescale 1ns / 1ps
// channel | dir | beat contents
// req     | in  | tdata: func, byte_index, write_value, seg_start, seg_len, rotate_amount
// rsp     | out | tdata: read_value, clamped_start, clamped_len
// csr     | in  | used_size
// A write answers through the result state, a read through read-wait and result;
// a reverse swaps pairs, each pair through next, read, read, write, write states;
// rotate first runs the bit-serial modulo, then three reversal passes
// with about len pairs of swaps in all on the one-write, one-read store.
// Reset is synchronous; the byte store is not cleared. The front queue takes
// the next command while the back end works or a result waits on rsp_tready.
module byte_segment_reverse_rotate_core #(
   parameter int BUF_DEPTH = bsrr_pkg::BufDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // func[1:0], byte_index[9:2], write_value[17:10], seg_start[33:18],
   // seg_len[49:34], rotate_amount[65:50], zero fill
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_value[7:0], clamped_start[15:8], clamped_len[24:16], zero fill
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data
);

   logic [8:0] used_size_ff;
   logic       cmd_valid, cmd_ready;
   bsrr_pkg::cmd_type cmd_data;
   logic [7:0] rv, st;
   logic [8:0] ln;

   // configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) used_size_ff <= 9'd256;
      else if (csr_valid) used_size_ff <= csr_data;
   end

   bsrr_front #(.BUF_DEPTH(BUF_DEPTH)) u_front (
      .clock, .reset, .used_size(used_size_ff),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .func(req_tdata[1:0]), .byte_index(req_tdata[9:2]),
      .write_value(req_tdata[17:10]), .seg_start(req_tdata[33:18]),
      .seg_len(req_tdata[49:34]), .rotate_amount(req_tdata[65:50]),
      .cmd_valid, .cmd_ready, .cmd_data
   );

   bsrr_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data,
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .rsp_read_value(rv), .rsp_start(st), .rsp_len(ln)
   );

   assign rsp_tdata = {7'd0, ln, st, rv};

endmodule

/* bench/bsrr_checker.sv */
`timescale 1ns / 1ps

module bsrr_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [8:0]  csr_data,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic [7:0] read_value;
      logic [7:0] clamped_start;
      logic [8:0] clamped_len;
   } answer_type;

   logic [7:0] shadow_store [0:bsrr_pkg::BufDepth-1];
   logic [8:0] shadow_size;
   answer_type answer_queue [$];

   // swap the bytes of one span end for end
   function automatic void flip_span(input int first, input int count);
      logic [7:0] t;
      for (int k = 0; k < count / 2; k++) begin
         t = shadow_store[first + k];
         shadow_store[first + k] = shadow_store[first + count - 1 - k];
         shadow_store[first + count - 1 - k] = t;
      end
   endfunction

   // apply one command to the shadow store and return its answer
   function automatic answer_type apply_command(input logic [71:0] d);
      bsrr_pkg::func_type f;
      int         size, start, len, end_pos, amount, sh;
      answer_type a;
      f      = bsrr_pkg::func_type'(d[1:0]);
      start  = $signed(d[33:18]);
      len    = $signed(d[49:34]);
      amount = $signed(d[65:50]);
      size   = shadow_size;
      if (size < 1) size = 1;
      if (size > bsrr_pkg::BufDepth) size = bsrr_pkg::BufDepth;
      if (start < 0) begin
         start = size + start;
         if (start < 0) start = 0;
      end else if (start >= size) begin
         start = size - 1;
      end
      if (len <= 0) begin
         end_pos = size + len;
         if (end_pos < 0) end_pos = 0;
      end else begin
         end_pos = start + len;
         if (end_pos > size) end_pos = size;
      end
      len = end_pos - start;
      if (len < 1) len = 0;
      a = '0;
      case (f)
         bsrr_pkg::FUNC_WRITE: shadow_store[d[9:2]] = d[17:10];
         bsrr_pkg::FUNC_READ: a.read_value = shadow_store[d[9:2]];
         bsrr_pkg::FUNC_REVERSE: flip_span(start, len);
         default: begin
            if (len > 0) begin
               sh = amount % len;
               if (sh < 0) sh += len;
               flip_span(start, sh);
               flip_span(start + sh, len - sh);
               flip_span(start, len);
            end
         end
      endcase
      a.clamped_start = start[7:0];
      a.clamped_len   = len[8:0];
      return a;
   endfunction

   assign pending_count = answer_queue.size();

   // predict on each request beat, compare on each response beat
   always @(posedge clock) begin
      answer_type got, want;
      if (reset) begin
         shadow_size <= 9'd256;
         answer_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) shadow_size <= csr_data;
         if (req_tvalid && req_tready) answer_queue.push_back(apply_command(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[24:16]};
            if (answer_queue.size() == 0) begin
               $error("response beat with nothing expected: %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = answer_queue.pop_front();
               if (got !== want) begin
                  fail_count <= fail_count + 1;
                  if (got.read_value !== want.read_value)
                     $error("read_value expected %0d actual %0d",
                            want.read_value, got.read_value);
                  if (got.clamped_start !== want.clamped_start)
                     $error("clamped_start expected %0d actual %0d",
                            want.clamped_start, got.clamped_start);
                  if (got.clamped_len !== want.clamped_len)
                     $error("clamped_len expected %0d actual %0d",
                            want.clamped_len, got.clamped_len);
               end
            end
         end
      end
   end

endmodule

/* bench/tb_byte_segment_reverse_rotate_core.sv */
`timescale 1ns / 1ps

module tb_byte_segment_reverse_rotate_core;

   localparam int CycleLimit = 5_000_000;
   localparam int HoldCycles = 3000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [8:0]  csr_data;
   int          fail_count;
   int          pending_count;
   int          send_idle_pct;
   int          recv_stall_pct;
   bit          hold_go;
   int          cycle_count;
   logic [8:0]  cur_size;
   bit          written [0:bsrr_pkg::BufDepth-1];

   byte_segment_reverse_rotate_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   bsrr_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // bound the run
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CycleLimit) begin
            $display("tb_byte_segment_reverse_rotate_core failed");
            $finish;
         end
      end
   end

   // response side: random stall, or one long hold once asked
   initial begin
      int held;
      held = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && held < HoldCycles) begin
            rsp_tready <= 1'b0;
            held++;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // a read touches only bytes already written
   function automatic int pick_written_index();
      int idx;
      do idx = $urandom_range(255); while (!written[idx]);
      return idx;
   endfunction

   // offer one beat; valid stays high so beats can follow back to back
   task automatic send_beat(input bsrr_pkg::func_type f, input logic [7:0] idx,
                            input logic [7:0] wval, input logic [15:0] st,
                            input logic [15:0] ln, input logic [15:0] amt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {6'd0, amt, ln, st, wval, idx, f};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_size(input logic [8:0] value);
      int waited;
      req_tvalid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (pending_count != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      // let the last command retire fully
      repeat (20) @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_size = value;
   endtask

   // mostly in-range segment fields, sometimes wild
   function automatic logic [15:0] seg_value();
      int r;
      r = $urandom_range(9);
      if (r < 6) return 16'($urandom_range(cur_size + 8));
      if (r < 8) return 16'(-$signed($urandom_range(cur_size + 8)));
      return 16'($urandom);
   endfunction

   task automatic random_items(input int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(9);
         if (r < 3) begin
            send_beat(bsrr_pkg::FUNC_WRITE, 8'($urandom), 8'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
         end else if (r < 5) begin
            send_beat(bsrr_pkg::FUNC_READ, 8'(pick_written_index()), 8'($urandom),
                      seg_value(), seg_value(), 16'($urandom));
         end else if (r < 7) begin
            send_beat(bsrr_pkg::FUNC_REVERSE, 8'($urandom), 8'($urandom), seg_value(),
                      seg_value(), 16'($urandom));
         end else begin
            send_beat(bsrr_pkg::FUNC_ROTATE, 8'($urandom), 8'($urandom), seg_value(),
                      seg_value(),
                      (r == 9) ? 16'($urandom) : 16'($signed($urandom_range(600)) - 300));
         end
      end
   endtask

   initial begin
      int waited;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_go = 1'b0;
      cur_size = 9'd256;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the whole store so every later read sees written data
      for (int i = 0; i < bsrr_pkg::BufDepth; i++) begin
         send_beat(bsrr_pkg::FUNC_WRITE, 8'(i), 8'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom));
         written[i] = 1'b1;
      end

      // directed: extremes, each command, clamping corners, zero-length rotate
      send_beat(bsrr_pkg::FUNC_WRITE, 8'hFF, 8'hFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_beat(bsrr_pkg::FUNC_WRITE, 8'h00, 8'h00, 16'h8000, 16'h8000, 16'h8000);
      send_beat(bsrr_pkg::FUNC_READ, 8'hFF, 8'h00, 16'h0000, 16'h0000, 16'h0000);
      send_beat(bsrr_pkg::FUNC_READ, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_beat(bsrr_pkg::FUNC_REVERSE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000);
      send_beat(bsrr_pkg::FUNC_REVERSE, 8'h00, 8'h00, 16'h0010, 16'h0008, 16'h0000);
      send_beat(bsrr_pkg::FUNC_REVERSE, 8'h00, 8'h00, 16'h8000, 16'h7FFF, 16'h0000);
      send_beat(bsrr_pkg::FUNC_REVERSE, 8'h00, 8'h00, 16'h7FFF, 16'h0001, 16'h0000);
      send_beat(bsrr_pkg::FUNC_ROTATE, 8'h00, 8'h00, 16'h0004, 16'h000A, 16'h0003);
      send_beat(bsrr_pkg::FUNC_ROTATE, 8'h00, 8'h00, 16'h0004, 16'h000A, 16'hFFFD);
      send_beat(bsrr_pkg::FUNC_ROTATE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h7FFF);
      send_beat(bsrr_pkg::FUNC_ROTATE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h8000);
      send_beat(bsrr_pkg::FUNC_ROTATE, 8'h00, 8'h00, 16'h0050, 16'hFFC0, 16'h0001);
      send_beat(bsrr_pkg::FUNC_ROTATE, 8'h00, 8'h00, 16'h0020, 16'h8000, 16'h0005);
      send_beat(bsrr_pkg::FUNC_ROTATE, 8'h00, 8'h00, 16'hFFF0, 16'h0000, 16'h0011);
      send_beat(bsrr_pkg::FUNC_READ, 8'h10, 8'h00, 16'h0000, 16'h0001, 16'h0000);

      // size corners: the smallest sizes, one and two
      write_size(9'd1);
      send_beat(bsrr_pkg::FUNC_ROTATE, 8'h00, 8'h00, 16'h0005, 16'h0005, 16'h0001);
      send_beat(bsrr_pkg::FUNC_REVERSE, 8'h00, 8'h00, 16'hFFFF, 16'h0000, 16'h0000);
      random_items(20);
      write_size(9'd2);
      random_items(20);

      // pressure: hold the response side while requests keep coming
      write_size(9'd16);
      hold_go = 1'b1;
      random_items(20);

      write_size(9'd37);
      send_idle_pct = 73;
      random_items(60);
      write_size(9'd256);
      send_idle_pct = 0;
      recv_stall_pct = 73;
      random_items(50);
      write_size(9'd100);
      send_idle_pct = 32;
      recv_stall_pct = 32;
      random_items(60);
      write_size(9'd0);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      random_items(20);
      write_size(9'd511);
      random_items(26);

      req_tvalid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (pending_count != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (600) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_byte_segment_reverse_rotate_core passed");
      end else begin
         if (pending_count != 0) $error("%0d responses never arrived", pending_count);
         $display("tb_byte_segment_reverse_rotate_core failed");
      end
      $finish;
   end

endmodule
